// ===== hw/rtl/mts_pkg.sv =====
// Package for the min tracking stack: field widths, opcode and status codes,
// the stored entry format and the controller/datapath command and status structs.
// Depends on nothing.
`default_nettype none

package mts_pkg;

   localparam int DATA_W              = 32;
   localparam int OP_W                = 2;
   localparam int ST_W                = 2;
   localparam int DEFAULT_STACK_DEPTH = 256;

   localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP   = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

   // one stack entry: its value and the minimum of it and all entries below
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] run_min;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic exec;      // accept the item on the request ports
      logic load_top;  // move the fetched entry into the top registers
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_fetch;  // pending request is a pop that exposes a stored entry
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mts_ctrl.sv =====
// Controller for the min tracking stack: handshake state machine.
// Depends on mts_pkg.
`default_nettype none

module mts_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  wire mts_pkg::dp_stat_type stat,
   output mts_pkg::dp_cmd_type  cmd
);
   import mts_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_RESP  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      req_ready    = (state_ff == S_IDLE) || ((state_ff == S_RESP) && rsp_ready);
      rsp_valid    = (state_ff == S_RESP);
      accept       = req_valid && req_ready;
      cmd.exec     = accept;
      cmd.load_top = (state_ff == S_FETCH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = stat.need_fetch ? S_FETCH : S_RESP;
         end
         S_FETCH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (accept) state_in = stat.need_fetch ? S_FETCH : S_RESP;
            else if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mts_dp.sv =====
// Datapath for the min tracking stack: entry memory, top registers,
// entry count and result status.
// Depends on mts_pkg.
`default_nettype none

module mts_dp #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire         [mts_pkg::OP_W-1:0]    req_opcode,
   input  wire  signed [mts_pkg::DATA_W-1:0]  req_push_value,
   input  wire  mts_pkg::dp_cmd_type          cmd,
   output mts_pkg::dp_stat_type               stat,
   output logic signed [mts_pkg::DATA_W-1:0]  rsp_top_value,
   output logic signed [mts_pkg::DATA_W-1:0]  rsp_min_value,
   output logic                               rsp_is_empty,
   output logic        [mts_pkg::ST_W-1:0]    rsp_op_status
);
   import mts_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE        = CW'(1);
   localparam logic [CW-1:0] TWO        = CW'(2);

   entry_type mem [STACK_DEPTH];
   entry_type rd_ff;

   logic        [CW-1:0]     count_ff, count_in;
   logic signed [DATA_W-1:0] top_val_ff, top_val_in;
   logic signed [DATA_W-1:0] top_min_ff, top_min_in;
   logic        [ST_W-1:0]   status_ff, status_in;

   logic                     is_push, is_pop, empty, full, do_push, do_pop;
   logic signed [DATA_W-1:0] new_min;
   logic        [CW-1:0]     below_idx;
   logic        [AW-1:0]     wr_addr, rd_addr;

   always_comb begin
      is_push   = (req_opcode == OP_PUSH);
      is_pop    = (req_opcode == OP_POP);
      empty     = (count_ff == '0);
      full      = (count_ff == FULL_COUNT);
      do_push   = cmd.exec && is_push && !full;
      do_pop    = cmd.exec && is_pop && !empty;
      below_idx = count_ff - TWO;
      wr_addr   = count_ff[AW-1:0];
      rd_addr   = below_idx[AW-1:0];

      stat.need_fetch = is_pop && (count_ff >= TWO);

      if (empty || (req_push_value < top_min_ff)) new_min = req_push_value;
      else new_min = top_min_ff;

      count_in   = count_ff;
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      status_in  = status_ff;

      if (cmd.exec) begin
         status_in = ST_OK;
         if (is_push && full) status_in = ST_FULL;
         if (is_pop && empty) status_in = ST_EMPTY;
      end
      if (do_push) begin
         count_in   = count_ff + ONE;
         top_val_in = req_push_value;
         top_min_in = new_min;
      end
      if (do_pop) count_in = count_ff - ONE;
      if (cmd.load_top) begin
         top_val_in = rd_ff.value;
         top_min_in = rd_ff.run_min;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_push) mem[wr_addr] <= '{value: req_push_value, run_min: new_min};
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      status_ff  <= status_in;
   end

   always_comb begin
      rsp_is_empty  = empty;
      rsp_top_value = empty ? '1 : top_val_ff;
      rsp_min_value = empty ? '1 : top_min_ff;
      rsp_op_status = status_ff;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/min_tracking_stack.sv =====
// Top level of the min tracking stack: controller plus datapath.
// Depends on mts_pkg, mts_ctrl and mts_dp.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one item: an opcode
//   (query, push, pop; code 3 acts as query) and a signed push value.
//   The response channel (rsp_valid/rsp_ready) returns one item per request:
//   top value, current minimum (both all ones when empty), an empty flag and
//   a status (ok, push dropped because full, pop on empty ignored).
//   A query, a push, or a pop that leaves the stack empty or exposes
//   nothing stored shows its result in the cycle after acceptance. A pop that
//   exposes a stored entry passes through a fetch state first, for the
//   registered read of the entry memory.
//   Throughput: one item per cycle for queries and pushes while the receiver
//   takes results; such pops take no new item during their fetch state.
//   A new item is accepted in the same cycle the waiting result is taken.
//   When the receiver stalls, the result holds and no new item is accepted.
//   Reset empties the stack at once; memory contents are not cleared.
`default_nettype none

module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire         [mts_pkg::OP_W-1:0]    req_opcode,
   input  wire  signed [mts_pkg::DATA_W-1:0]  req_push_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [mts_pkg::DATA_W-1:0]  rsp_top_value,
   output logic signed [mts_pkg::DATA_W-1:0]  rsp_min_value,
   output logic                               rsp_is_empty,
   output logic        [mts_pkg::ST_W-1:0]    rsp_op_status
);
   import mts_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequence the handshakes and the fetch cycle of a pop
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the stack, the top entry in registers and the result status
   mts_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_op_status  (rsp_op_status)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/mts_checker.sv =====
// Port-level checker for the min tracking stack, bound to the top level.
// Depends on min_tracking_stack and mts_pkg.
`default_nettype none

module mts_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire signed [mts_pkg::DATA_W-1:0]   rsp_top_value,
   input wire signed [mts_pkg::DATA_W-1:0]   rsp_min_value,
   input wire                                rsp_is_empty,
   input wire        [mts_pkg::ST_W-1:0]     rsp_op_status
);
   import mts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_min_value) && $stable(rsp_op_status))
      else $error("stalled result changed");

   a_empty_reads: assert property (@(posedge clock) disable iff (reset)
      rsp_is_empty |-> (rsp_top_value == '1) && (rsp_min_value == '1))
      else $error("empty stack must read all ones");

   a_min_le_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> rsp_min_value <= rsp_top_value)
      else $error("minimum above top value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_op_status == ST_OK) || (rsp_op_status == ST_FULL)
         || (rsp_op_status == ST_EMPTY))
      else $error("bad status code");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_top_value (rsp_top_value),
   .rsp_min_value (rsp_min_value),
   .rsp_is_empty  (rsp_is_empty),
   .rsp_op_status (rsp_op_status)
);

`default_nettype wire
